// ----- rtl/lsfs_pkg.sv -----
package lsfs_pkg;

   localparam int NUM_LEDS    = 16;
   localparam int START_BYTES = 8;
   localparam int END_BYTES   = 8;

   localparam int LED_BYTES = 4 * NUM_LEDS;
   localparam int POS_MAX   = (LED_BYTES > 64) ? LED_BYTES : 64;
   localparam int POS_W     = $clog2(POS_MAX + 1);
   localparam int ADDR_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   localparam logic [1:0] CMD_SET_ONE   = 2'd0;
   localparam logic [1:0] CMD_SET_ALL   = 2'd1;
   localparam logic [1:0] CMD_XMIT      = 2'd2;
   localparam logic [1:0] CMD_BYTE_SENT = 2'd3;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_LED   = 2'd2;
   localparam logic [1:0] PH_END   = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  led_index;
      logic [28:0] color_word;
   } lsfs_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } lsfs_rsp_type;

   typedef struct packed {
      logic       wr_one;
      logic       fill_load;
      logic       fill_en;
      logic       emit;
      logic [1:0] phase;
   } lsfs_dp_cmd_type;

   typedef struct packed {
      logic wrap;
      logic fill_done;
   } lsfs_dp_stat_type;

endpackage

// ----- rtl/lsfs_datapath.sv -----
module lsfs_datapath
   import lsfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  lsfs_req_type     req_item,
   input  lsfs_dp_cmd_type  dp_cmd,
   output lsfs_dp_stat_type dp_stat,
   output logic             rsp_strobe,
   output lsfs_rsp_type     rsp_item
);

   logic [28:0]       mem [NUM_LEDS];
   logic [28:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [28:0]       wr_data;
   logic              mem_we;

   logic [ADDR_W-1:0] fill_cnt_ff, fill_cnt_in;
   logic [28:0]       fill_value_ff, fill_value_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  pos_next;
   logic              wrap;
   logic [7:0]        byte_val;
   logic              rsp_strobe_ff, rsp_strobe_in;
   lsfs_rsp_type      rsp_item_ff, rsp_item_in;

   assign rd_addr = pos_ff[ADDR_W+1:2];
   assign mem_we  = dp_cmd.wr_one | dp_cmd.fill_en;
   assign wr_addr = dp_cmd.fill_en ? fill_cnt_ff : ADDR_W'(req_item.led_index);
   assign wr_data = dp_cmd.fill_en ? fill_value_ff : req_item.color_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // fill sweep: walk every entry, one per cycle
   always_comb begin
      fill_cnt_in   = fill_cnt_ff;
      fill_value_in = fill_value_ff;
      if (dp_cmd.fill_load) begin
         fill_cnt_in   = '0;
         fill_value_in = req_item.color_word;
      end else if (dp_cmd.fill_en) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
      end
   end

   assign dp_stat.fill_done = (fill_cnt_ff == ADDR_W'(NUM_LEDS - 1));

   assign pos_next = pos_ff + 1'b1;

   always_comb begin
      case (dp_cmd.phase)
         PH_START: wrap = (pos_next >= POS_W'(START_BYTES));
         PH_LED:   wrap = (pos_next >= POS_W'(LED_BYTES));
         PH_END:   wrap = (pos_next >= POS_W'(END_BYTES));
         default:  wrap = 1'b0;
      endcase
   end

   assign dp_stat.wrap = wrap;

   always_comb begin
      case (dp_cmd.phase)
         PH_LED: begin
            case (pos_ff[1:0])
               2'd0:    byte_val = 8'hE0 | {3'b000, rd_data_ff[28:24]};
               2'd1:    byte_val = rd_data_ff[23:16];
               2'd2:    byte_val = rd_data_ff[7:0];
               default: byte_val = rd_data_ff[15:8];
            endcase
         end
         PH_END:  byte_val = 8'hFF;
         default: byte_val = 8'h00;
      endcase
   end

   always_comb begin
      pos_in                 = pos_ff;
      rsp_strobe_in          = 1'b0;
      rsp_item_in            = rsp_item_ff;
      if (dp_cmd.emit) begin
         pos_in                 = wrap ? '0 : pos_next;
         rsp_strobe_in          = 1'b1;
         rsp_item_in.out_byte   = byte_val;
         rsp_item_in.frame_last = wrap && (dp_cmd.phase == PH_END);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff   <= '0;
         fill_value_ff <= '0;
         pos_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_cnt_ff   <= fill_cnt_in;
         fill_value_ff <= fill_value_in;
         pos_ff        <= pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ----- rtl/lsfs_ctrl.sv -----
module lsfs_ctrl
   import lsfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lsfs_req_type     req_item,
   input  lsfs_dp_stat_type dp_stat,
   output logic             busy,
   output lsfs_dp_cmd_type  dp_cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       pending_ff, pending_in;
   logic       accept;
   logic       idx_ok;

   assign accept = start && (state_ff == ST_IDLE);
   assign idx_ok = (32'(req_item.led_index) < NUM_LEDS);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      pending_in       = pending_ff;
      dp_cmd.wr_one    = 1'b0;
      dp_cmd.fill_load = 1'b0;
      dp_cmd.fill_en   = 1'b0;
      dp_cmd.emit      = 1'b0;
      dp_cmd.phase     = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.cmd)
                  CMD_SET_ONE: dp_cmd.wr_one = idx_ok;
                  CMD_SET_ALL: begin
                     dp_cmd.fill_load = 1'b1;
                     state_in         = ST_FILL;
                  end
                  CMD_XMIT: begin
                     if (phase_ff == PH_IDLE) begin
                        phase_in = PH_START;
                        state_in = ST_EMIT;
                     end else begin
                        pending_in = 1'b1;
                     end
                  end
                  default: begin
                     if (phase_ff != PH_IDLE) begin
                        state_in = ST_EMIT;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            dp_cmd.fill_en = 1'b1;
            if (dp_stat.fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            dp_cmd.emit = 1'b1;
            state_in    = ST_IDLE;
            if (dp_stat.wrap) begin
               case (phase_ff)
                  PH_START: phase_in = PH_LED;
                  PH_LED:   phase_in = PH_END;
                  PH_END: begin
                     if (pending_ff) begin
                        phase_in   = PH_START;
                        pending_in = 1'b0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         phase_ff   <= PH_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- rtl/led_strip_frame_serializer.sv -----
// Byte commands (transmit request, byte sent): busy through the emit state, result registered
// and strobed after it; a new transaction is taken once busy falls.
// Set-one, request-while-busy and idle byte-sent: no busy time. Set-all: busy during the fill.
// Reset (synchronous, active high) clears control state and then sweeps zeros into the
// whole table with busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
module led_strip_frame_serializer
   import lsfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  lsfs_req_type req_item,
   output logic         rsp_strobe,
   output lsfs_rsp_type rsp_item
);

   // Controller owns the sequencing state, the frame phase and the
   // pending-repeat flag; the datapath owns the color table, the byte
   // position counter, the fill sweep and the result register.
   lsfs_dp_cmd_type  dp_cmd;
   lsfs_dp_stat_type dp_stat;

   // Decode accepted transactions, sequence fill and emit cycles,
   // advance the frame phase when the position wraps.
   lsfs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .dp_stat  (dp_stat),
      .busy     (busy),
      .dp_cmd   (dp_cmd)
   );

   // Table read is registered: the entry for the current LED is captured
   // at the accepting edge, formatted in the emit cycle, then registered
   // onto the result ports.
   lsfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
